FILE: hdl/pva_pkg.sv
package pva_pkg;

  localparam int NUM_CHANNELS = 64;
  localparam int AGE_BITS     = 32;
  localparam int IDX_W        = $clog2(NUM_CHANNELS);
  localparam int CNT_W        = $clog2(NUM_CHANNELS + 1);

  localparam logic [7:0] PRIO_LIMIT = 8'hff;
  localparam logic [7:0] KILL_LIMIT = 8'h7f;

  typedef enum logic [1:0] {
    ST_ACTIVE   = 2'd0,
    ST_INACTIVE = 2'd1,
    ST_RELEASE  = 2'd2,
    ST_SPARE    = 2'd3
  } chan_st_t;

  typedef enum logic [2:0] {
    K_ALLOC       = 3'd0,
    K_ALLOC_FORCE = 3'd1,
    K_START       = 3'd2,
    K_SET_PRIO    = 3'd3,
    K_REL_CB      = 3'd4,
    K_KILL        = 3'd5,
    K_UPDATE      = 3'd6,
    K_BAD         = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    DSP_NONE    = 3'd0,
    DSP_FINISH  = 3'd1,
    DSP_FSTOP   = 3'd2,
    DSP_START   = 3'd3,
    DSP_INIT    = 3'd4,
    DSP_FLUSH   = 3'd5,
    DSP_NOACC   = 3'd6,
    DSP_PSTOP   = 3'd7
  } dsp_t;

  typedef enum logic [2:0] {
    CB_NONE       = 3'd0,
    CB_STOP       = 3'd1,
    CB_BEGIN      = 3'd2,
    CB_BEGIN_STOP = 3'd3,
    CB_PLAY       = 3'd4,
    CB_PLAY_STOP  = 3'd5
  } cbs_t;

  // request sequencer states
  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_SEEK, S_APPLY, S_OUT
  } fsm_t;

  // one channel record
  typedef struct packed {
    logic                free;
    logic [7:0]          prio;
    logic [AGE_BITS-1:0] age;
    chan_st_t            st;
    logic                start_p;
    logic                stop_p;
    logic                cb;
  } chan_t;

  // best-candidate token passed along the cell row
  typedef struct packed {
    logic            found;
    logic            hit_free;
    logic [8:0]      prio;    // signed-like: free counts below 0 via bit 8
    logic [AGE_BITS-1:0] age;
    logic [IDX_W-1:0] idx;
  } best_t;

  typedef struct packed {
    logic            scan;     // alloc scan (1) or kill scan (0)
    logic [7:0]      req;
  } scan_ctl_t;

endpackage

FILE: hdl/pva_cell.sv
// One storage cell of the rotating channel ring. When shift is high the ring moves
// by one cell; the head cell's record is compared against the running best.
module pva_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                shift,
  input  pva_pkg::chan_t      rst_val,
  input  pva_pkg::chan_t      d,
  output pva_pkg::chan_t      q
);

  pva_pkg::chan_t q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= rst_val;
    end else if (shift) begin
      q_r <= d;
    end
  end

  assign q = q_r;

endmodule

FILE: hdl/pva_pick.sv
// Compares the head channel against the running best and updates it.
module pva_pick (
  input  pva_pkg::scan_ctl_t          ctl,
  input  pva_pkg::chan_t              ch,
  input  logic [pva_pkg::IDX_W-1:0]   idx,
  input  pva_pkg::best_t              best_in,
  output pva_pkg::best_t              best_out
);

  logic [8:0] p;
  logic       take;

  always_comb begin
    best_out = best_in;
    take     = 1'b0;
    p        = {1'b0, ch.prio};
    if (ctl.scan) begin
      if (!best_in.hit_free) begin
        if (ch.free) begin
          best_out.hit_free = 1'b1;
          best_out.found    = 1'b1;
          best_out.idx      = idx;
        end else begin
          take = (p <= {1'b0, ctl.req}) && (p <= best_in.prio) &&
                 ((p != best_in.prio) || (ch.age > best_in.age));
        end
      end
    end else if (ch.st == pva_pkg::ST_ACTIVE) begin
      // free counts as -1: bit 8 set, below everything in the custom order
      if (ch.free) begin
        take = !best_in.prio[8] || (ch.age > best_in.age);
        p    = 9'h100;
      end else begin
        take = !best_in.prio[8] && (ch.prio < pva_pkg::KILL_LIMIT) &&
               (p <= best_in.prio) &&
               ((p != best_in.prio) || (ch.age > best_in.age));
      end
    end
    if (take) begin
      best_out.found = 1'b1;
      best_out.prio  = p;
      best_out.age   = ch.age;
      best_out.idx   = idx;
    end
  end

endmodule

FILE: hdl/priority_voice_allocator.sv
// Priority voice allocator: 64 channel records in a rotating ring of cells.
// Alloc and kill rotate the ring until channel 0 is the head, compare all N cells,
// decide, then seek the chosen channel and apply the edit if one was found.
// Other kinds seek their channel and apply; an unknown kind goes to the result.
// One request in flight; the next is accepted in the cycle after the result goes.
// Reset (synchronous, rst_n low) marks every channel free and inactive.
module priority_voice_allocator (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_kind,
  input  logic [5:0] in_channel,
  input  logic [7:0] in_priority_req,
  input  logic       in_has_callback,
  input  logic       in_dsp_finished,
  input  logic       in_first_cb_negative,
  input  logic       in_stop_cb_negative,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_ok,
  output logic [5:0] out_chosen_channel,
  output logic       out_drop_notify,
  output logic [2:0] out_dsp_action,
  output logic [2:0] out_callbacks_issued,
  output logic       out_freed
);

  localparam int N = pva_pkg::NUM_CHANNELS;
  localparam int IW = pva_pkg::IDX_W;
  localparam int CW = pva_pkg::CNT_W;

  pva_pkg::fsm_t state_r, state_nxt;

  // ring: cell 0 is the head; the head holds channel head_r
  pva_pkg::chan_t ring_q [N];
  pva_pkg::chan_t ring_d [N];
  pva_pkg::chan_t head_new;
  logic           shift;
  logic [IW-1:0]  head_r, head_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  // latched request
  pva_pkg::kind_t kind_r;
  logic [5:0]     chan_r;
  logic [7:0]     prio_r;
  logic           hcb_r, fin_r, fneg_r, sneg_r;
  logic [IW-1:0]  target_r, target_nxt;
  logic           tvalid_r, tvalid_nxt;

  pva_pkg::best_t    best_r, best_nxt, best_cmp;
  pva_pkg::scan_ctl_t ctl;

  // result register
  logic       ok_r, ok_nxt, ntf_r, ntf_nxt, frd_r, frd_nxt;
  logic [5:0] ch_r, ch_nxt;
  logic [2:0] dsp_r, dsp_nxt, cbs_r, cbs_nxt;

  pva_pkg::chan_t rst_rec;
  assign rst_rec = '{free: 1'b1, prio: 8'd0, age: '0, st: pva_pkg::ST_INACTIVE,
                     start_p: 1'b0, stop_p: 1'b0, cb: 1'b0};

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_ring
      // rotate: cell g takes cell g+1, last takes the (possibly edited) head
      if (g == N - 1) begin : g_last
        assign ring_d[g] = head_new;
      end else begin : g_mid
        assign ring_d[g] = ring_q[g+1];
      end
      pva_cell u_cell (
        .clk(clk), .rst_n(rst_n), .shift(shift), .rst_val(rst_rec),
        .d(ring_d[g]), .q(ring_q[g])
      );
    end
  endgenerate

  assign ctl.scan = (kind_r != pva_pkg::K_KILL);
  assign ctl.req  = prio_r;

  pva_pick u_pick (
    .ctl(ctl), .ch(ring_q[0]), .idx(head_r), .best_in(best_r), .best_out(best_cmp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= pva_pkg::S_IDLE;
      head_r   <= '0;
      cnt_r    <= '0;
      tvalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      cnt_r    <= cnt_nxt;
      tvalid_r <= tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == pva_pkg::S_IDLE && in_valid) begin
      kind_r <= pva_pkg::kind_t'(in_kind);
      chan_r <= in_channel;
      prio_r <= in_priority_req;
      hcb_r  <= in_has_callback;
      fin_r  <= in_dsp_finished;
      fneg_r <= in_first_cb_negative;
      sneg_r <= in_stop_cb_negative;
    end
    best_r   <= best_nxt;
    target_r <= target_nxt;
    ok_r  <= ok_nxt;
    ch_r  <= ch_nxt;
    ntf_r <= ntf_nxt;
    dsp_r <= dsp_nxt;
    cbs_r <= cbs_nxt;
    frd_r <= frd_nxt;
  end

  // result fields and head edit logic for the apply step
  pva_pkg::chan_t h;
  always_comb begin
    h        = ring_q[0];
    head_new = h;
    ok_nxt   = ok_r;
    ch_nxt   = ch_r;
    ntf_nxt  = ntf_r;
    dsp_nxt  = dsp_r;
    cbs_nxt  = cbs_r;
    frd_nxt  = frd_r;
    if (state_r == pva_pkg::S_IDLE) begin
      // default result fields for the new request
      ok_nxt  = (in_kind != pva_pkg::K_BAD);
      ch_nxt  = in_channel;
      ntf_nxt = 1'b0;
      dsp_nxt = pva_pkg::DSP_NONE;
      cbs_nxt = pva_pkg::CB_NONE;
      frd_nxt = 1'b0;
    end
    if (state_r == pva_pkg::S_SCAN && cnt_r == CW'(N)) begin
      ok_nxt = best_r.found;
      ch_nxt = best_r.found ? 6'(best_r.idx) : 6'd0;
    end
    if (state_r == pva_pkg::S_APPLY && tvalid_r) begin
      case (kind_r)
        pva_pkg::K_ALLOC, pva_pkg::K_ALLOC_FORCE, pva_pkg::K_KILL: begin
          ntf_nxt = h.cb;
          if (kind_r == pva_pkg::K_ALLOC_FORCE) begin
            h.st = pva_pkg::ST_INACTIVE;
          end
          h.cb      = 1'b0;
          h.free    = 1'b1;
          h.start_p = 1'b0;
          if (h.st == pva_pkg::ST_ACTIVE) begin
            h.stop_p = 1'b1;
            h.st     = pva_pkg::ST_RELEASE;
          end
          if (kind_r != pva_pkg::K_KILL) begin
            h.prio = prio_r;
            h.free = 1'b0;
            h.age  = '0;
            h.cb   = hcb_r;
          end
        end
        pva_pkg::K_START:    h.start_p = 1'b1;
        pva_pkg::K_SET_PRIO: begin
          h.prio = prio_r;
          h.free = 1'b0;
        end
        pva_pkg::K_REL_CB:   h.cb = 1'b0;
        pva_pkg::K_UPDATE: begin
          if (fin_r) begin
            h.stop_p = 1'b0;
            if (h.st == pva_pkg::ST_ACTIVE) begin
              if (h.cb) cbs_nxt = pva_pkg::CB_STOP;
              if (!h.cb || sneg_r) begin
                h.free  = 1'b1;
                frd_nxt = 1'b1;
              end
            end
            h.st    = pva_pkg::ST_INACTIVE;
            dsp_nxt = pva_pkg::DSP_FINISH;
          end else if (h.stop_p) begin
            h.stop_p = 1'b0;
            dsp_nxt  = pva_pkg::DSP_FSTOP;
          end else if (h.st != pva_pkg::ST_RELEASE) begin
            if (h.start_p && h.st == pva_pkg::ST_INACTIVE) begin
              h.start_p = 1'b0;
              h.st      = pva_pkg::ST_ACTIVE;
              if (h.cb && fneg_r) begin
                h.st    = pva_pkg::ST_INACTIVE;
                cbs_nxt = pva_pkg::CB_BEGIN_STOP;
                if (sneg_r) begin
                  h.free  = 1'b1;
                  frd_nxt = 1'b1;
                end
                dsp_nxt = pva_pkg::DSP_INIT;
              end else begin
                cbs_nxt = h.cb ? pva_pkg::CB_BEGIN : pva_pkg::CB_NONE;
                dsp_nxt = pva_pkg::DSP_START;
              end
            end else if (h.st != pva_pkg::ST_INACTIVE) begin
              // active or the unused code
              if (h.cb && fneg_r) begin
                h.st    = pva_pkg::ST_INACTIVE;
                cbs_nxt = pva_pkg::CB_PLAY_STOP;
                if (sneg_r) begin
                  h.free  = 1'b1;
                  frd_nxt = 1'b1;
                end
                dsp_nxt = pva_pkg::DSP_PSTOP;
              end else begin
                h.age   = h.age + 1'b1;
                cbs_nxt = h.cb ? pva_pkg::CB_PLAY : pva_pkg::CB_NONE;
                dsp_nxt = h.cb ? pva_pkg::DSP_FLUSH : pva_pkg::DSP_NOACC;
              end
            end
          end
        end
        default: ;
      endcase
      head_new = h;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    cnt_nxt    = cnt_r;
    shift      = 1'b0;
    best_nxt   = best_r;
    target_nxt = target_r;
    tvalid_nxt = tvalid_r;
    in_stall   = (state_r != pva_pkg::S_IDLE);
    case (state_r)
      pva_pkg::S_IDLE: begin
        if (in_valid) begin
          best_nxt = '{found: 1'b0, hit_free: 1'b0, prio: {1'b0, pva_pkg::PRIO_LIMIT},
                       age: '0, idx: '0};
          cnt_nxt  = '0;
          if (in_kind inside {pva_pkg::K_ALLOC, pva_pkg::K_ALLOC_FORCE, pva_pkg::K_KILL})
          begin
            state_nxt = pva_pkg::S_SCAN;
          end else if (in_kind == pva_pkg::K_BAD) begin
            state_nxt = pva_pkg::S_OUT;
          end else if ({2'b0, in_channel} < 8'(N)) begin
            target_nxt = IW'(in_channel);
            tvalid_nxt = 1'b1;
            state_nxt  = pva_pkg::S_SEEK;
          end else begin
            state_nxt = pva_pkg::S_OUT;
          end
        end
      end
      pva_pkg::S_SCAN: begin
        // visits channels head_r .. head_r+N-1 in ring order; channel order
        // matters for ties, so the scan starts when head is channel 0
        if (head_r == '0 && cnt_r == '0) begin
          best_nxt = best_cmp;
          cnt_nxt  = CW'(1);
          shift    = 1'b1;
          head_nxt = IW'(head_r + 1'b1);
        end else if (cnt_r != '0) begin
          if (cnt_r == CW'(N)) begin
            target_nxt = best_r.idx;
            tvalid_nxt = best_r.found;
            state_nxt  = best_r.found ? pva_pkg::S_SEEK : pva_pkg::S_OUT;
          end else begin
            best_nxt = best_cmp;
            cnt_nxt  = CW'(cnt_r + 1'b1);
            shift    = 1'b1;
            head_nxt = IW'(head_r + 1'b1);
          end
        end else begin
          shift    = 1'b1;
          head_nxt = IW'(head_r + 1'b1);
        end
      end
      pva_pkg::S_SEEK: begin
        if (head_r == target_r) begin
          state_nxt = pva_pkg::S_APPLY;
        end else begin
          shift    = 1'b1;
          head_nxt = IW'(head_r + 1'b1);
        end
      end
      pva_pkg::S_APPLY: begin
        // write the edited head back by rotating it to the tail
        shift      = 1'b1;
        head_nxt   = IW'(head_r + 1'b1);
        tvalid_nxt = 1'b0;
        state_nxt  = pva_pkg::S_OUT;
      end
      pva_pkg::S_OUT: begin
        if (!out_stall) state_nxt = pva_pkg::S_IDLE;
      end
      default: state_nxt = pva_pkg::S_IDLE;
    endcase
  end

  assign out_valid            = (state_r == pva_pkg::S_OUT);
  assign out_ok               = ok_r;
  assign out_chosen_channel   = ch_r;
  assign out_drop_notify      = ntf_r;
  assign out_dsp_action       = dsp_r;
  assign out_callbacks_issued = cbs_r;
  assign out_freed            = frd_r;

endmodule
